/* hdl/rsp_pkg.sv */
`default_nettype none
package rsp_pkg;

	localparam int unsigned COORD_BITS_DEF = 24;
	localparam int unsigned OUT_W = 32;
	localparam int unsigned CFG_W = 12;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned NUM_OPS = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_PLANE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROAD_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd2;

	localparam logic [CFG_W-1:0] PLANE_RST = 12'd256;
	localparam logic [CFG_W-1:0] ROAD_WIDTH_RST = 12'd140;
	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd8;

	typedef enum logic [2:0] {
		OP_TOP_Y,
		OP_LEFT,
		OP_RIGHT,
		OP_LINE_LEFT,
		OP_LINE_RIGHT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* hdl/rsp_in_if.sv */
`default_nettype none
interface rsp_in_if import rsp_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] cam_x;
	logic signed [COORD_BITS-1:0] cam_y;
	logic signed [COORD_BITS-1:0] cam_z;
	logic signed [COORD_BITS-1:0] seg_x;
	logic signed [COORD_BITS-1:0] seg_y;
	logic signed [COORD_BITS-1:0] seg_z;
	logic draw_line;

	modport source (
		output valid, cam_x, cam_y, cam_z, seg_x, seg_y, seg_z, draw_line,
		input ready
	);
	modport sink (
		input valid, cam_x, cam_y, cam_z, seg_x, seg_y, seg_z, draw_line,
		output ready
	);
endinterface
`default_nettype wire

/* hdl/rsp_out_if.sv */
`default_nettype none
interface rsp_out_if import rsp_pkg::*;;
	logic valid;
	logic ready;
	logic signed [OUT_W-1:0] top_y;
	logic signed [OUT_W-1:0] top_left_x;
	logic signed [OUT_W-1:0] top_right_x;
	logic signed [OUT_W-1:0] bottom_y;
	logic signed [OUT_W-1:0] bottom_left_x;
	logic signed [OUT_W-1:0] bottom_right_x;
	logic paint;
	logic line_valid;
	logic signed [OUT_W-1:0] line_top_left_x;
	logic signed [OUT_W-1:0] line_top_right_x;
	logic signed [OUT_W-1:0] line_bottom_left_x;
	logic signed [OUT_W-1:0] line_bottom_right_x;

	modport source (
		output valid, top_y, top_left_x, top_right_x, bottom_y, bottom_left_x,
		bottom_right_x, paint, line_valid, line_top_left_x, line_top_right_x,
		line_bottom_left_x, line_bottom_right_x,
		input ready
	);
	modport sink (
		input valid, top_y, top_left_x, top_right_x, bottom_y, bottom_left_x,
		bottom_right_x, paint, line_valid, line_top_left_x, line_top_right_x,
		line_bottom_left_x, line_bottom_right_x,
		output ready
	);
endinterface
`default_nettype wire

/* hdl/road_segment_projector_unit.sv */
`default_nettype none
// Projects one road segment per request into screen space. Each request is
// worked through five perspective divisions (top y, road left and right edge,
// lane line left and right edge), each a multiply by the projection plane
// followed by a radix-2 restoring divide by the clamped view depth on one
// shared multiply and divide unit. A request is taken in and passes a setup
// state, then for each division a multiply state, the divide states and a
// finish state, and is handed from the done state to the output register.
// The divider produces one quotient bit per cycle. The input is not ready
// while a request is in work. The result waits in an output register, so a
// new request can be taken while the previous result is not yet consumed. The
// bottom edge of each quad is the top edge of the previous request, kept in
// registers that reset clears. Configuration is to be written only while the
// block is idle; the block itself does not enforce this.
module road_segment_projector_unit import rsp_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	rsp_in_if.sink item,
	rsp_out_if.source result
);

	localparam int unsigned OPND_W = COORD_BITS + 2;
	localparam int unsigned PROD_W = OPND_W + CFG_W + 1;
	localparam int unsigned MAG_W = COORD_BITS + 13;
	localparam int unsigned DEN_W = COORD_BITS;
	localparam int unsigned SAT_W = (MAG_W > OUT_W + 1) ? MAG_W : OUT_W + 1;
	localparam int unsigned CNT_W = $clog2(MAG_W);
	localparam int unsigned HALF_W = CFG_W - 1;
	localparam logic [SAT_W-1:0] POS_LIM = SAT_W'({1'b0, {(OUT_W-1){1'b1}}});
	localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'({1'b1, {(OUT_W-1){1'b0}}});

	state_t state_q, state_d;
	logic load_out;

	logic [CFG_W-1:0] plane_q, road_width_q, line_width_q;

	logic signed [COORD_BITS-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [COORD_BITS-1:0] seg_x_q, seg_y_q, seg_z_q;
	logic draw_q;

	logic signed [OUT_W-1:0] last_top_y_q, last_top_left_x_q, last_top_right_x_q;
	logic signed [OUT_W-1:0] last_line_left_x_q, last_line_right_x_q;
	logic signed [COORD_BITS-1:0] last_seg_z_q;

	op_t op_q;
	logic [DEN_W-1:0] den_q;
	logic [MAG_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [OUT_W-1:0] res_q [NUM_OPS];

	logic out_valid_q;
	logic signed [OUT_W-1:0] top_y_q, top_left_x_q, top_right_x_q;
	logic signed [OUT_W-1:0] bottom_y_q, bottom_left_x_q, bottom_right_x_q;
	logic paint_q, line_valid_q;
	logic signed [OUT_W-1:0] line_top_left_x_q, line_top_right_x_q;
	logic signed [OUT_W-1:0] line_bottom_left_x_q, line_bottom_right_x_q;

	logic signed [COORD_BITS:0] vx, vy, vz;
	logic [OPND_W-1:0] half_road, half_line, vx_ext, vy_ext;
	logic signed [OPND_W-1:0] opnd;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_u, prod_mag;
	logic [DEN_W-1:0] den_clamp;
	logic [DEN_W:0] trial, diff;
	logic fits;
	logic [SAT_W-1:0] qext;
	logic signed [OUT_W-1:0] sat_val;
	logic behind, no_advance, too_thin, paint_c, line_c;

	assign item.ready = (state_q == ST_IDLE);

	always_comb begin
		vx = {seg_x_q[COORD_BITS-1], seg_x_q} - {cam_x_q[COORD_BITS-1], cam_x_q};
		vy = {cam_y_q[COORD_BITS-1], cam_y_q} - {seg_y_q[COORD_BITS-1], seg_y_q};
		vz = {seg_z_q[COORD_BITS-1], seg_z_q} - {cam_z_q[COORD_BITS-1], cam_z_q};
		half_road = {{(OPND_W-HALF_W){1'b0}}, road_width_q[CFG_W-1:1]};
		half_line = {{(OPND_W-HALF_W){1'b0}}, line_width_q[CFG_W-1:1]};
		vx_ext = {vx[COORD_BITS], vx};
		vy_ext = {vy[COORD_BITS], vy};
		case (op_q)
			OP_TOP_Y: opnd = vy_ext;
			OP_LEFT: opnd = vx_ext - half_road;
			OP_RIGHT: opnd = vx_ext + half_road;
			OP_LINE_LEFT: opnd = vx_ext - half_line;
			OP_LINE_RIGHT: opnd = vx_ext + half_line;
			default: opnd = vy_ext;
		endcase
		prod = opnd * $signed({1'b0, plane_q});
		prod_u = prod;
		prod_mag = prod_u[PROD_W-1] ? (~prod_u + 1'b1) : prod_u;

		if (vz[COORD_BITS] || vz == '0) begin
			den_clamp = DEN_W'(1);
		end else begin
			den_clamp = vz[DEN_W-1:0];
		end

		trial = {rem_q, num_q[MAG_W-1]};
		fits = trial >= {1'b0, den_q};
		diff = trial - {1'b0, den_q};

		qext = SAT_W'(num_q);
		if (neg_q) begin
			sat_val = (qext > NEG_LIM) ? $signed(NEG_LIM[OUT_W-1:0])
				: $signed(~qext[OUT_W-1:0] + 1'b1);
		end else begin
			sat_val = (qext > POS_LIM) ? $signed(POS_LIM[OUT_W-1:0])
				: $signed(qext[OUT_W-1:0]);
		end

		behind = last_seg_z_q <= cam_z_q;
		no_advance = seg_z_q <= last_seg_z_q;
		too_thin = res_q[OP_TOP_Y] >= last_top_y_q;
		paint_c = !(behind || no_advance || too_thin);
		line_c = paint_c && draw_q;
	end

	always_comb begin
		state_d = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item.valid) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = ST_MUL;
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(MAG_W - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = (op_q == OP_LINE_RIGHT) ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_RST;
			road_width_q <= ROAD_WIDTH_RST;
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PLANE: plane_q <= cfg_data;
				CFG_ROAD_WIDTH: road_width_q <= cfg_data;
				CFG_LINE_WIDTH: line_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			cam_x_q <= item.cam_x;
			cam_y_q <= item.cam_y;
			cam_z_q <= item.cam_z;
			seg_x_q <= item.seg_x;
			seg_y_q <= item.seg_y;
			seg_z_q <= item.seg_z;
			draw_q <= item.draw_line;
		end
		case (state_q)
			ST_SETUP: begin
				den_q <= den_clamp;
				op_q <= OP_TOP_Y;
			end
			ST_MUL: begin
				num_q <= prod_mag[MAG_W-1:0];
				neg_q <= prod_u[PROD_W-1];
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				num_q <= {num_q[MAG_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_FIN: begin
				res_q[op_q] <= sat_val;
				if (op_q != OP_LINE_RIGHT) op_q <= op_t'(op_q + 3'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_top_y_q <= '0;
			last_top_left_x_q <= '0;
			last_top_right_x_q <= '0;
			last_line_left_x_q <= '0;
			last_line_right_x_q <= '0;
			last_seg_z_q <= '0;
		end else if (load_out) begin
			last_top_y_q <= res_q[OP_TOP_Y];
			last_top_left_x_q <= res_q[OP_LEFT];
			last_top_right_x_q <= res_q[OP_RIGHT];
			last_line_left_x_q <= res_q[OP_LINE_LEFT];
			last_line_right_x_q <= res_q[OP_LINE_RIGHT];
			last_seg_z_q <= seg_z_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			top_y_q <= res_q[OP_TOP_Y];
			top_left_x_q <= res_q[OP_LEFT];
			top_right_x_q <= res_q[OP_RIGHT];
			bottom_y_q <= last_top_y_q;
			bottom_left_x_q <= last_top_left_x_q;
			bottom_right_x_q <= last_top_right_x_q;
			paint_q <= paint_c;
			line_valid_q <= line_c;
			line_top_left_x_q <= line_c ? res_q[OP_LINE_LEFT] : '0;
			line_top_right_x_q <= line_c ? res_q[OP_LINE_RIGHT] : '0;
			line_bottom_left_x_q <= line_c ? last_line_left_x_q : '0;
			line_bottom_right_x_q <= line_c ? last_line_right_x_q : '0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.top_y = top_y_q;
	assign result.top_left_x = top_left_x_q;
	assign result.top_right_x = top_right_x_q;
	assign result.bottom_y = bottom_y_q;
	assign result.bottom_left_x = bottom_left_x_q;
	assign result.bottom_right_x = bottom_right_x_q;
	assign result.paint = paint_q;
	assign result.line_valid = line_valid_q;
	assign result.line_top_left_x = line_top_left_x_q;
	assign result.line_top_right_x = line_top_right_x_q;
	assign result.line_bottom_left_x = line_bottom_left_x_q;
	assign result.line_bottom_right_x = line_bottom_right_x_q;

endmodule
`default_nettype wire

/* hdl/rsp_checker.sv */
`default_nettype none
module rsp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic paint,
	input wire logic line_valid,
	input wire logic [31:0] line_top_left_x,
	input wire logic [31:0] line_top_right_x,
	input wire logic [31:0] line_bottom_left_x,
	input wire logic [31:0] line_bottom_right_x
);

	// A stalled result must stay offered.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result request dropped while stalled");

	a_line_needs_paint: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && line_valid |-> paint)
		else $error("lane line valid without paint");

	a_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !line_valid |-> line_top_left_x == '0 && line_top_right_x == '0
			&& line_bottom_left_x == '0 && line_bottom_right_x == '0)
		else $error("lane line corners not cleared");

	// The unit works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input ready right after a request was taken");

endmodule

bind road_segment_projector_unit rsp_checker u_rsp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.paint(result.paint),
	.line_valid(result.line_valid),
	.line_top_left_x(result.line_top_left_x),
	.line_top_right_x(result.line_top_right_x),
	.line_bottom_left_x(result.line_bottom_left_x),
	.line_bottom_right_x(result.line_bottom_right_x)
);
`default_nettype wire

/* test/road_segment_projector_unit_tb.sv */
`timescale 1ns / 1ps
module road_segment_projector_unit_tb;
	import rsp_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int COORD_MIN = -(2 ** (CB - 1));
	localparam int COORD_MAX = 2 ** (CB - 1) - 1;
	localparam longint SCREEN_MAX = 64'sh7FFF_FFFF;
	localparam longint SCREEN_MIN = -64'sh8000_0000;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [OUT_W-1:0] screen_t;

	typedef struct {
		coord_t cam_x;
		coord_t cam_y;
		coord_t cam_z;
		coord_t seg_x;
		coord_t seg_y;
		coord_t seg_z;
		logic draw_line;
	} segment_t;

	typedef struct {
		screen_t top_y;
		screen_t top_left_x;
		screen_t top_right_x;
		screen_t bottom_y;
		screen_t bottom_left_x;
		screen_t bottom_right_x;
		logic paint;
		logic line_valid;
		screen_t line_top_left_x;
		screen_t line_top_right_x;
		screen_t line_bottom_left_x;
		screen_t line_bottom_right_x;
	} quad_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rsp_in_if #(.COORD_BITS(CB)) item_bus ();
	rsp_out_if result_bus ();

	road_segment_projector_unit #(.COORD_BITS(CB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_bus),
		.result(result_bus)
	);

	logic [CFG_W-1:0] plane_dist;
	logic [CFG_W-1:0] road_w;
	logic [CFG_W-1:0] line_w;
	longint prev_top_y;
	longint prev_left_x;
	longint prev_right_x;
	longint prev_seg_z;
	longint prev_line_left;
	longint prev_line_right;

	quad_t pending_quads[$];
	int mismatch_count = 0;
	bit steady = 1'b0;

	always #5 clk = ~clk;

	function automatic longint perspective(input longint v, input longint depth);
		longint q;
		if (depth < 1) begin
			depth = 1;
		end
		q = (v * longint'(plane_dist)) / depth;
		if (q > SCREEN_MAX) begin
			q = SCREEN_MAX;
		end
		if (q < SCREEN_MIN) begin
			q = SCREEN_MIN;
		end
		return q;
	endfunction

	function automatic quad_t project_segment(input segment_t s);
		quad_t r;
		longint vx, vy, vz, half_road, half_line;
		longint ty, tl, tr, ll, lr;
		logic paint;
		vx = longint'(s.seg_x) - longint'(s.cam_x);
		vy = longint'(s.cam_y) - longint'(s.seg_y);
		vz = longint'(s.seg_z) - longint'(s.cam_z);
		half_road = longint'(road_w >> 1);
		half_line = longint'(line_w >> 1);
		ty = perspective(vy, vz);
		tl = perspective(vx - half_road, vz);
		tr = perspective(vx + half_road, vz);
		ll = perspective(vx - half_line, vz);
		lr = perspective(vx + half_line, vz);
		paint = !(prev_seg_z <= longint'(s.cam_z) || longint'(s.seg_z) <= prev_seg_z
			|| ty >= prev_top_y);
		r.top_y = screen_t'(ty);
		r.top_left_x = screen_t'(tl);
		r.top_right_x = screen_t'(tr);
		r.bottom_y = screen_t'(prev_top_y);
		r.bottom_left_x = screen_t'(prev_left_x);
		r.bottom_right_x = screen_t'(prev_right_x);
		r.paint = paint;
		r.line_valid = paint && s.draw_line;
		r.line_top_left_x = r.line_valid ? screen_t'(ll) : '0;
		r.line_top_right_x = r.line_valid ? screen_t'(lr) : '0;
		r.line_bottom_left_x = r.line_valid ? screen_t'(prev_line_left) : '0;
		r.line_bottom_right_x = r.line_valid ? screen_t'(prev_line_right) : '0;
		prev_top_y = ty;
		prev_left_x = tl;
		prev_right_x = tr;
		prev_seg_z = longint'(s.seg_z);
		prev_line_left = ll;
		prev_line_right = lr;
		return r;
	endfunction

	function automatic coord_t any_coord();
		case ($urandom_range(0, 7))
			0: return coord_t'(COORD_MIN);
			1: return coord_t'(COORD_MAX);
			2: return '0;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic segment_t any_segment();
		segment_t s;
		s.cam_x = any_coord();
		s.cam_y = any_coord();
		s.cam_z = any_coord();
		s.seg_x = any_coord();
		s.seg_y = any_coord();
		s.seg_z = any_coord();
		s.draw_line = 1'($urandom_range(0, 1));
		return s;
	endfunction

	function automatic segment_t make_seg(input int cx, input int cy, input int cz,
			input int sx, input int sy, input int sz, input logic dl);
		segment_t s;
		s.cam_x = coord_t'(cx);
		s.cam_y = coord_t'(cy);
		s.cam_z = coord_t'(cz);
		s.seg_x = coord_t'(sx);
		s.seg_y = coord_t'(sy);
		s.seg_z = coord_t'(sz);
		s.draw_line = dl;
		return s;
	endfunction

	function automatic logic [CFG_W-1:0] pick_reg(input int lo);
		case ($urandom_range(0, 5))
			0: return CFG_W'(lo);
			1: return CFG_W'(4095);
			default: return CFG_W'($urandom_range(lo, 4095));
		endcase
	endfunction

	task automatic check_field(input string name, input screen_t want, input screen_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic send_segment(input segment_t s);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.cam_x <= s.cam_x;
		item_bus.cam_y <= s.cam_y;
		item_bus.cam_z <= s.cam_z;
		item_bus.seg_x <= s.seg_x;
		item_bus.seg_y <= s.seg_y;
		item_bus.seg_z <= s.seg_z;
		item_bus.draw_line <= s.draw_line;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		pending_quads.insert(pending_quads.size(), project_segment(s));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (pending_quads.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PLANE: plane_dist = value;
			CFG_ROAD_WIDTH: road_w = value;
			CFG_LINE_WIDTH: line_w = value;
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic [CFG_W-1:0] plane, input logic [CFG_W-1:0] road,
			input logic [CFG_W-1:0] line);
		wait_idle();
		write_reg(CFG_PLANE, plane);
		write_reg(CFG_ROAD_WIDTH, road);
		write_reg(CFG_LINE_WIDTH, line);
	endtask

	// A frame holds the camera still and walks the segments away from it along z,
	// with a curving x, small hills and some broken or arbitrary requests mixed in.
	task automatic run_frame(input int count, input int noise_pct);
		segment_t s, t;
		int cam_x, cam_z, base_y, z, seg_len, x, dx, y, i;
		cam_x = int'($urandom_range(0, 20000)) - 10000;
		cam_z = int'($urandom_range(0, 8000000)) - 4000000;
		base_y = int'($urandom_range(0, 2000000)) - 1000000;
		seg_len = $urandom_range(1, 500);
		z = cam_z + int'($urandom_range(1, 300));
		x = cam_x + int'($urandom_range(0, 400)) - 200;
		dx = 0;
		y = base_y;
		s.cam_x = coord_t'(cam_x);
		s.cam_y = coord_t'(base_y + int'($urandom_range(1, 3000)));
		s.cam_z = coord_t'(cam_z);
		for (i = 0; i < count; i++) begin
			s.seg_x = coord_t'(x);
			s.seg_y = coord_t'(y);
			s.seg_z = coord_t'(z);
			s.draw_line = ($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : 1'((i / 2) % 2);
			t = s;
			if (int'($urandom_range(0, 99)) < noise_pct) begin
				case ($urandom_range(0, 2))
					0: t = any_segment();
					1: t.seg_z = coord_t'(z - seg_len);
					default: t.cam_z = coord_t'(z + int'($urandom_range(0, 50)));
				endcase
			end
			send_segment(t);
			z += seg_len;
			dx += int'($urandom_range(0, 40)) - 20;
			x += dx;
			y += int'($urandom_range(0, 60)) - 30;
		end
	endtask

	task automatic test_reset_registers();
		send_segment(make_seg(0, 0, 0, 0, 0, 0, 1'b0));
		send_segment(make_seg(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
		send_segment(make_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
		send_segment(make_seg(0, COORD_MAX, 0, COORD_MAX, COORD_MIN, 1, 1'b1));
		send_segment(make_seg(0, COORD_MIN, 0, COORD_MIN, COORD_MAX, 1, 1'b0));
		send_segment(make_seg(0, 500, 0, 37, 0, 100, 1'b1));
		send_segment(make_seg(0, 500, 0, -37, 0, 200, 1'b1));
		send_segment(make_seg(0, 500, 0, -75, 0, 300, 1'b0));
		send_segment(make_seg(0, 500, 0, -75, 0, 300, 1'b1));
		send_segment(make_seg(0, 500, 400, -90, 0, 500, 1'b1));
		send_segment(make_seg(0, 500, 400, -90, 0, 600, 1'b1));
		send_segment(make_seg(0, 500, 400, -91, -500, 601, 1'b1));
		send_segment(make_seg(0, 500, 400, -91, 0, 700, 1'b1));
	endtask

	task automatic test_register_extremes();
		set_registers(CFG_W'(1), CFG_W'(0), CFG_W'(0));
		run_frame(3, 0);
		send_segment(any_segment());
		set_registers(CFG_W'(4095), CFG_W'(4095), CFG_W'(4095));
		run_frame(3, 0);
		send_segment(any_segment());
		set_registers(CFG_W'(2), CFG_W'(141), CFG_W'(9));
		run_frame(3, 0);
		send_segment(any_segment());
	endtask

	task automatic test_random_frames();
		int phase, sent, n;
		for (phase = 0; phase < 10; phase++) begin
			set_registers(pick_reg(1), pick_reg(0), pick_reg(0));
			steady = (phase == 3);
			sent = 0;
			while (sent < 95) begin
				n = $urandom_range(2, 40);
				run_frame(n, 15);
				sent += n;
			end
		end
		steady = 1'b0;
	endtask

	initial begin : result_checker
		int stall;
		quad_t want;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			@(negedge clk);
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_bus.ready <= 1'b1;
			@(posedge clk);
			while (!result_bus.valid) @(posedge clk);
			if (pending_quads.size() == 0) begin
				$error("Result arrived with no request outstanding.");
				mismatch_count++;
			end else begin
				want = pending_quads.pop_front();
				check_field("top_y", want.top_y, result_bus.top_y);
				check_field("top_left_x", want.top_left_x, result_bus.top_left_x);
				check_field("top_right_x", want.top_right_x, result_bus.top_right_x);
				check_field("bottom_y", want.bottom_y, result_bus.bottom_y);
				check_field("bottom_left_x", want.bottom_left_x, result_bus.bottom_left_x);
				check_field("bottom_right_x", want.bottom_right_x, result_bus.bottom_right_x);
				check_field("paint", screen_t'(want.paint), screen_t'(result_bus.paint));
				check_field("line_valid", screen_t'(want.line_valid),
					screen_t'(result_bus.line_valid));
				check_field("line_top_left_x", want.line_top_left_x, result_bus.line_top_left_x);
				check_field("line_top_right_x", want.line_top_right_x,
					result_bus.line_top_right_x);
				check_field("line_bottom_left_x", want.line_bottom_left_x,
					result_bus.line_bottom_left_x);
				check_field("line_bottom_right_x", want.line_bottom_right_x,
					result_bus.line_bottom_right_x);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_bus.valid = 1'b0;
		item_bus.cam_x = '0;
		item_bus.cam_y = '0;
		item_bus.cam_z = '0;
		item_bus.seg_x = '0;
		item_bus.seg_y = '0;
		item_bus.seg_z = '0;
		item_bus.draw_line = 1'b0;
		result_bus.ready = 1'b0;
		plane_dist = PLANE_RST;
		road_w = ROAD_WIDTH_RST;
		line_w = LINE_WIDTH_RST;
		prev_top_y = 0;
		prev_left_x = 0;
		prev_right_x = 0;
		prev_seg_z = 0;
		prev_line_left = 0;
		prev_line_right = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_registers();
		test_register_extremes();
		test_random_frames();

		wait_idle();
		repeat (250) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/rsp_pkg.sv
hdl/rsp_in_if.sv
hdl/rsp_out_if.sv
hdl/road_segment_projector_unit.sv
hdl/rsp_checker.sv
test/road_segment_projector_unit_tb.sv
